@@ rtl/wsfd_pkg.sv @@
package wsfd_pkg;

  localparam int LEN_W = 17;

  // largest payload a frame may announce
  localparam logic [LEN_W-1:0] MAX_PAYLOAD = 17'd65536;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_SHORT = 2'd1;
  localparam status_t ST_BIG   = 2'd2;

  typedef logic [LEN_W-1:0] len_t;

endpackage

@@ rtl/wsfd_if.sv @@
interface wsfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface wsfd_tx_if;
  logic             valid;
  logic             ready;
  logic [7:0]       payload_byte;
  logic             byte_valid;
  logic             frame_end;
  wsfd_pkg::status_t status;
  logic             fin_bit;
  logic [3:0]       frame_opcode;
  wsfd_pkg::len_t   payload_length;

  modport source (output valid, output payload_byte, output byte_valid, output frame_end,
                  output status, output fin_bit, output frame_opcode,
                  output payload_length, input ready);
  modport sink (input valid, input payload_byte, input byte_valid, input frame_end,
                input status, input fin_bit, input frame_opcode,
                input payload_length, output ready);
endinterface

interface wsfd_cfg_if;
  logic           valid;
  logic           ready;
  wsfd_pkg::len_t out_capacity;

  modport source (output valid, output out_capacity, input ready);
  modport sink (input valid, input out_capacity, output ready);
endinterface

@@ rtl/websocket_frame_decoder_core.sv @@
// a byte transferred on rx is registered in s1; its result (if any) is then written to the result buffer that drives tx
// throughput: one byte per cycle while rx.ready stays high; the header parser and unmask step run in a single pass
// a two-entry result buffer absorbs tx stalls; rx.ready drops only when it would overflow
// rst (synchronous, active high) clears the frame state, empties both buffers
// and sets out_capacity to 65536
module websocket_frame_decoder_core (
  input logic     clk,
  input logic     rst,
  wsfd_rx_if.sink   rx,
  wsfd_tx_if.source tx,
  wsfd_cfg_if.sink  cfg
);
  import wsfd_pkg::*;

  // parser phases
  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_ERR  = 3'd6;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_end;
    status_t    status;
    logic       fin_bit;
    logic [3:0] frame_opcode;
    len_t       payload_length;
  } res_t;

  // configuration
  len_t out_capacity;

  // input register
  logic       s1_v;
  logic [7:0] s1_byte;
  logic       s1_end;

  // frame state
  logic [2:0]  phase;
  logic [3:0]  header_count;
  logic        fin_flag;
  logic [3:0]  opcode_reg;
  logic        masked_flag;
  len_t        length_acc;
  logic        length_over;
  logic [31:0] key_bytes;
  len_t        payload_count;
  status_t     pending_error;

  logic [2:0]  phase_next;
  logic [3:0]  header_count_next;
  logic        fin_flag_next;
  logic [3:0]  opcode_reg_next;
  logic        masked_flag_next;
  len_t        length_acc_next;
  logic        length_over_next;
  logic [31:0] key_bytes_next;
  len_t        payload_count_next;
  status_t     pending_error_next;

  logic res_v;
  res_t res;

  // result buffer, two entries
  res_t       rbuf [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] ocnt;
  logic       push;
  logic       pop;

  assign cfg.ready = 1'b1;

  // a byte may enter s1 only if, after this edge, a slot is still free for it;
  // counting the tx transfer of this edge keeps bytes flowing every cycle
  assign rx.ready = (ocnt == 2'd0) ||
                    ((ocnt == 2'd1) && (!s1_v || pop)) ||
                    ((ocnt == 2'd2) && !s1_v && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= MAX_PAYLOAD;
    end else if (cfg.valid && cfg.ready) begin
      out_capacity <= cfg.out_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= rx.valid && rx.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.data_byte;
      s1_end  <= rx.buffer_end;
    end
  end

  // one byte step of the deframer
  always_comb begin
    logic [1:0] k;
    logic [7:0] ub;
    logic       hdr_fin;

    phase_next         = phase;
    header_count_next  = header_count;
    fin_flag_next      = fin_flag;
    opcode_reg_next    = opcode_reg;
    masked_flag_next   = masked_flag;
    length_acc_next    = length_acc;
    length_over_next   = length_over;
    key_bytes_next     = key_bytes;
    payload_count_next = payload_count;
    pending_error_next = pending_error;
    res_v              = 1'b0;
    res                = '0;
    hdr_fin            = 1'b0;
    k                  = payload_count[1:0];
    ub                 = s1_byte ^ key_bytes[8*k +: 8];

    case (phase)
      PH_HDR0: begin
        fin_flag_next   = s1_byte[7];
        opcode_reg_next = s1_byte[3:0];
        phase_next      = PH_HDR1;
      end
      PH_HDR1: begin
        masked_flag_next = s1_byte[7];
        length_acc_next  = '0;
        length_over_next = 1'b0;
        if (s1_byte[6:0] < 7'd126) begin
          length_acc_next = {{(LEN_W-7){1'b0}}, s1_byte[6:0]};
          if (s1_byte[7]) begin
            header_count_next = 4'd4;
            phase_next        = PH_KEY;
          end else begin
            hdr_fin = 1'b1;
          end
        end else begin
          header_count_next = (s1_byte[6:0] == 7'd126) ? 4'd2 : 4'd8;
          phase_next        = PH_EXT;
        end
      end
      PH_EXT: begin
        // lengths that would overflow 17 bits are only flagged
        if (length_over || (length_acc >= len_t'(512))) begin
          length_over_next = 1'b1;
        end else begin
          length_acc_next = {length_acc[LEN_W-9:0], s1_byte};
        end
        header_count_next = header_count - 4'd1;
        if (header_count_next == 4'd0) begin
          if (masked_flag) begin
            header_count_next = 4'd4;
            phase_next        = PH_KEY;
          end else begin
            hdr_fin = 1'b1;
          end
        end
      end
      PH_KEY: begin
        k = 2'd0 - header_count[1:0];
        key_bytes_next[8*k +: 8] = key_bytes[8*k +: 8] | s1_byte;
        header_count_next = header_count - 4'd1;
        if (header_count_next == 4'd0) begin
          hdr_fin = 1'b1;
        end
      end
      PH_DATA: begin
        payload_count_next = payload_count + len_t'(1);
        if (payload_count_next >= length_acc) begin
          if (pending_error == ST_OK) begin
            res_v              = 1'b1;
            res.payload_byte   = ub;
            res.byte_valid     = 1'b1;
            res.frame_end      = 1'b1;
            res.payload_length = length_acc;
            phase_next         = PH_DONE;
          end else begin
            phase_next = PH_ERR;
          end
        end else if (pending_error == ST_OK) begin
          res_v            = 1'b1;
          res.payload_byte = ub;
          res.byte_valid   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // header complete: length checks, then payload or empty frame
    if (hdr_fin) begin
      if (length_over_next || (length_acc_next > MAX_PAYLOAD)) begin
        pending_error_next = ST_BIG;
        phase_next         = PH_ERR;
      end else begin
        pending_error_next = (length_acc_next > out_capacity) ? ST_BIG : ST_OK;
        payload_count_next = '0;
        if (length_acc_next == '0) begin
          res_v         = 1'b1;
          res.frame_end = 1'b1;
          phase_next    = PH_DONE;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end

    // buffer end: report short or pending error, then start a fresh header
    if (s1_end) begin
      if ((phase_next <= PH_KEY) || (phase_next == PH_DATA)) begin
        res_v     = 1'b1;
        res       = '0;
        res.frame_end = 1'b1;
        res.status    = ST_SHORT;
      end else if (phase_next == PH_ERR) begin
        res_v     = 1'b1;
        res       = '0;
        res.frame_end = 1'b1;
        res.status    = pending_error_next;
      end
    end

    // header fields as they stand after this byte
    res.fin_bit      = fin_flag_next;
    res.frame_opcode = opcode_reg_next;

    if (s1_end) begin
      phase_next         = PH_HDR0;
      header_count_next  = '0;
      fin_flag_next      = 1'b0;
      opcode_reg_next    = '0;
      masked_flag_next   = 1'b0;
      length_acc_next    = '0;
      length_over_next   = 1'b0;
      key_bytes_next     = '0;
      payload_count_next = '0;
      pending_error_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      header_count  <= '0;
      fin_flag      <= 1'b0;
      opcode_reg    <= '0;
      masked_flag   <= 1'b0;
      length_acc    <= '0;
      length_over   <= 1'b0;
      key_bytes     <= '0;
      payload_count <= '0;
      pending_error <= ST_OK;
    end else if (s1_v) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      fin_flag      <= fin_flag_next;
      opcode_reg    <= opcode_reg_next;
      masked_flag   <= masked_flag_next;
      length_acc    <= length_acc_next;
      length_over   <= length_over_next;
      key_bytes     <= key_bytes_next;
      payload_count <= payload_count_next;
      pending_error <= pending_error_next;
    end
  end

  // result buffer: a slot is always free for the byte in s1
  assign push = s1_v && res_v;
  assign pop  = tx.valid && tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      ocnt   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      ocnt <= ocnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rbuf[wr_ptr] <= res;
    end
  end

  assign tx.valid          = (ocnt != 2'd0);
  assign tx.payload_byte   = rbuf[rd_ptr].payload_byte;
  assign tx.byte_valid     = rbuf[rd_ptr].byte_valid;
  assign tx.frame_end      = rbuf[rd_ptr].frame_end;
  assign tx.status         = rbuf[rd_ptr].status;
  assign tx.fin_bit        = rbuf[rd_ptr].fin_bit;
  assign tx.frame_opcode   = rbuf[rd_ptr].frame_opcode;
  assign tx.payload_length = rbuf[rd_ptr].payload_length;

endmodule

@@ rtl/wsfd_checker.sv @@
module wsfd_checker (
  input logic              clk,
  input logic              rst,
  input logic              tx_valid,
  input logic              tx_ready,
  input logic [7:0]        payload_byte,
  input logic              byte_valid,
  input logic              frame_end,
  input wsfd_pkg::status_t status,
  input wsfd_pkg::len_t    payload_length
);
  import wsfd_pkg::*;

  // status only travels with the end of a frame
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !frame_end |-> status == ST_OK)
    else $error("status set without frame_end");

  // no data byte on an errored end
  a_err_nodata: assert property (@(posedge clk) disable iff (rst)
    tx_valid && frame_end && (status != ST_OK) |-> !byte_valid && (payload_byte == 8'd0))
    else $error("payload byte carried with error status");

  // length only reported on a good frame end
  a_len_ok: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !(frame_end && (status == ST_OK)) |-> payload_length == '0)
    else $error("payload_length outside a good frame end");

  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(payload_byte) && $stable(status))
    else $error("stalled result changed");

endmodule

bind websocket_frame_decoder_core wsfd_checker u_wsfd_checker (
  .clk            (clk),
  .rst            (rst),
  .tx_valid       (tx.valid),
  .tx_ready       (tx.ready),
  .payload_byte   (tx.payload_byte),
  .byte_valid     (tx.byte_valid),
  .frame_end      (tx.frame_end),
  .status         (tx.status),
  .payload_length (tx.payload_length)
);

@@ verif/tb_websocket_frame_decoder_core.sv @@
`timescale 1ns / 100ps

module tb_websocket_frame_decoder_core;
  import wsfd_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // quiet cycles after the last result before a register write or the end
  localparam int SETTLE = 4;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 75;
  localparam int DIR_ROWS = 27;

  // one result transfer on tx, field for field
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_end;
    status_t     status;
    logic        fin_bit;
    logic [3:0]  frame_opcode;
    len_t        payload_length;
  } tx_item_t;

  // where the deframer is inside one receive buffer
  typedef enum logic [2:0] {
    HDR_FIRST, HDR_SECOND, EXT_LEN, HDR_KEY, PAYLOAD, FRAME_DONE, FRAME_ERR
  } deframe_state_t;

  // how a directed row is checked
  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    tx_item_t    lit;
  } dir_row_t;

  localparam tx_item_t NO_RESULT = '0;

  // directed buffers; literal results only where they are obvious
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // zero-length unmasked frame straight after reset, fin set, top opcode
    '{ROW_NONE,    8'h8F, 1'b0, NO_RESULT},
    '{ROW_RESULT,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 1'b1, 4'hF, 17'd0}},
    // buffer ends after the first header byte
    '{ROW_RESULT,  8'h81, 1'b1, '{8'h00, 1'b0, 1'b1, ST_SHORT, 1'b1, 4'h1, 17'd0}},
    // masked one-byte frame, then a trailing byte that must be ignored
    '{ROW_PREDICT, 8'h01, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'h81, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'hFF, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'h00, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'hA5, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'h5A, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'h3C, 1'b0, NO_RESULT},
    '{ROW_NONE,    8'hFF, 1'b1, NO_RESULT},
    // 64-bit length of all ones: overflows, too big on the last byte
    '{ROW_NONE,    8'h80, 1'b0, NO_RESULT},
    '{ROW_NONE,    8'h7F, 1'b0, NO_RESULT},
    '{ROW_NONE,    8'hFF, 1'b0, NO_RESULT},
    '{ROW_NONE,    8'hFF, 1'b0, NO_RESULT},
    '{ROW_NONE,    8'hFF, 1'b0, NO_RESULT},
    '{ROW_NONE,    8'hFF, 1'b0, NO_RESULT},
    '{ROW_NONE,    8'hFF, 1'b0, NO_RESULT},
    '{ROW_NONE,    8'hFF, 1'b0, NO_RESULT},
    '{ROW_NONE,    8'hFF, 1'b0, NO_RESULT},
    '{ROW_RESULT,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BIG, 1'b1, 4'h0, 17'd0}},
    // 16-bit length of 5, buffer falls short inside the payload
    '{ROW_PREDICT, 8'h02, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'h7E, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'h00, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'h05, 1'b0, NO_RESULT},
    '{ROW_PREDICT, 8'hAA, 1'b0, NO_RESULT},
    '{ROW_RESULT,  8'h55, 1'b1, '{8'h00, 1'b0, 1'b1, ST_SHORT, 1'b0, 4'h2, 17'd0}}
  };

  logic clk;
  logic rst;

  wsfd_rx_if  rx_bus ();
  wsfd_tx_if  tx_bus ();
  wsfd_cfg_if cfg_bus ();

  websocket_frame_decoder_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_bus),
    .tx  (tx_bus),
    .cfg (cfg_bus)
  );

  // results still owed by the block, oldest first
  tx_item_t decoded_q [$];
  // bytes of the receive buffer being built
  logic [7:0] frame_bytes [$];

  int unsigned mismatches;
  int unsigned tx_count;
  int unsigned stall_cycles;
  // no idling on either side while set
  bit steady;

  // predictor copy of the block's register and frame state
  len_t           capacity;
  deframe_state_t fsm;
  logic [3:0]     hdr_left;
  logic           fin_q;
  logic [3:0]     op_q;
  logic           mask_q;
  len_t           len_q;
  logic           over_q;
  logic [31:0]    key_q;
  len_t           pay_cnt;
  status_t        pend_q;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result %0d: %s", tx_count, msg);
  endtask

  task check_field(input string name, input int unsigned seen, input int unsigned want);
    if (seen != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, seen, want));
  endtask

  // back to the start of a new header
  task clear_frame();
    fsm = HDR_FIRST;
    hdr_left = '0;
    fin_q = 1'b0;
    op_q = '0;
    mask_q = 1'b0;
    len_q = '0;
    over_q = 1'b0;
    key_q = '0;
    pay_cnt = '0;
    pend_q = ST_OK;
  endtask

  function tx_item_t form_result(input logic [7:0] d, input logic v, input logic e,
                                 input status_t s, input len_t l);
    tx_item_t r;
    r.payload_byte = d;
    r.byte_valid = v;
    r.frame_end = e;
    r.status = s;
    r.fin_bit = fin_q;
    r.frame_opcode = op_q;
    r.payload_length = l;
    return r;
  endfunction

  // header complete: length checks, then payload or an empty frame
  task header_complete(inout bit got, inout tx_item_t res);
    if (over_q || len_q > MAX_PAYLOAD) begin
      pend_q = ST_BIG;
      fsm = FRAME_ERR;
    end else begin
      pend_q = (len_q > capacity) ? ST_BIG : ST_OK;
      pay_cnt = '0;
      if (len_q == '0) begin
        res = form_result(8'h00, 1'b0, 1'b1, ST_OK, '0);
        got = 1'b1;
        fsm = FRAME_DONE;
      end else begin
        fsm = PAYLOAD;
      end
    end
  endtask

  // one byte through the deframer; at most one result
  task deframe_byte(input logic [7:0] b_in, input logic last,
                    output bit got, output tx_item_t res);
    logic [7:0] b;
    int k;
    b = b_in;
    got = 1'b0;
    res = NO_RESULT;
    case (fsm)
      HDR_FIRST: begin
        fin_q = b[7];
        op_q = b[3:0];
        fsm = HDR_SECOND;
      end
      HDR_SECOND: begin
        mask_q = b[7];
        len_q = '0;
        over_q = 1'b0;
        if (b[6:0] < 7'd126) begin
          len_q = len_t'(b[6:0]);
          if (mask_q) begin
            hdr_left = 4'd4;
            fsm = HDR_KEY;
          end else begin
            header_complete(got, res);
          end
        end else begin
          hdr_left = (b[6:0] == 7'd126) ? 4'd2 : 4'd8;
          fsm = EXT_LEN;
        end
      end
      EXT_LEN: begin
        // anything from 512 upwards before the last byte cannot fit
        if (over_q || len_q >= 17'd512)
          over_q = 1'b1;
        else
          len_q = {len_q[8:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          if (mask_q) begin
            hdr_left = 4'd4;
            fsm = HDR_KEY;
          end else begin
            header_complete(got, res);
          end
        end
      end
      HDR_KEY: begin
        k = (4 - hdr_left) & 3;
        key_q[8*k +: 8] = b;
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0)
          header_complete(got, res);
      end
      PAYLOAD: begin
        k = pay_cnt[1:0];
        b = b ^ key_q[8*k +: 8];
        pay_cnt = pay_cnt + 17'd1;
        if (pay_cnt >= len_q) begin
          if (pend_q == ST_OK) begin
            res = form_result(b, 1'b1, 1'b1, ST_OK, len_q);
            got = 1'b1;
            fsm = FRAME_DONE;
          end else begin
            fsm = FRAME_ERR;
          end
        end else if (pend_q == ST_OK) begin
          res = form_result(b, 1'b1, 1'b0, ST_OK, '0);
          got = 1'b1;
        end
      end
      default: ;
    endcase
    // buffer end overrides whatever this byte produced, unless the frame is done
    if (last) begin
      if (fsm != FRAME_DONE && fsm != FRAME_ERR) begin
        res = form_result(8'h00, 1'b0, 1'b1, ST_SHORT, '0);
        got = 1'b1;
      end else if (fsm == FRAME_ERR) begin
        res = form_result(8'h00, 1'b0, 1'b1, pend_q, '0);
        got = 1'b1;
      end
      clear_frame();
    end
  endtask

  // one rx transfer with random idle cycles ahead of it outside the steady phase; called on a rising edge
  task push_byte(input logic [7:0] d, input logic e, input row_kind_t kind,
                 input tx_item_t lit);
    bit got;
    tx_item_t res;
    while (!steady && $urandom_range(99) < 28) begin
      rx_bus.valid <= 1'b0;
      @(posedge clk);
    end
    rx_bus.valid <= 1'b1;
    rx_bus.data_byte <= d;
    rx_bus.buffer_end <= e;
    do @(posedge clk); while (!rx_bus.ready);
    deframe_byte(d, e, got, res);
    if (kind == ROW_PREDICT) begin
      if (got)
        decoded_q.push_back(res);
    end else if (kind == ROW_RESULT) begin
      decoded_q.push_back(lit);
    end
  endtask

  // hold the sender until every owed result has arrived, then let the bus settle
  task drain();
    rx_bus.valid <= 1'b0;
    while (decoded_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_capacity(input len_t v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.out_capacity <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    capacity = v;
  endtask

  function len_t pick_capacity(input int ph);
    case (ph)
      0: return 17'd0;
      1: return 17'd65536;
      2: return len_t'($urandom_range(1, 40));
      3: return 17'd65535;
      4: return 17'd125;
      5: return 17'd1;
      6: return len_t'($urandom_range(0, 300));
      default: return 17'd65536;
    endcase
  endfunction

  // one receive buffer: mostly a well-formed frame, sometimes cut or padded, sometimes noise
  task build_random_buffer();
    int unsigned pick, body, ext_n, i, cut;
    logic [63:0] wire_len;
    logic masked;
    logic [6:0] len7;
    frame_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      // raw noise
      body = $urandom_range(1, 12);
      for (i = 0; i < body; i++)
        frame_bytes.push_back(8'($urandom));
    end else begin
      masked = 1'($urandom);
      ext_n = 0;
      pick = $urandom_range(99);
      if (pick < 55) begin
        wire_len = $urandom_range(0, 24);
      end else if (pick < 65) begin
        wire_len = $urandom_range(100, 125);
      end else if (pick < 80) begin
        ext_n = 2;
        wire_len = $urandom_range(0, 40);
      end else if (pick < 85) begin
        ext_n = 2;
        wire_len = $urandom_range(126, 65535);
      end else begin
        ext_n = 8;
        case ($urandom_range(3))
          0: wire_len = $urandom_range(0, 30);
          1: wire_len = 64'd65536 + $urandom_range(0, 1);
          2: wire_len = $urandom_range(60000, 65535);
          default: wire_len = {32'($urandom), 32'($urandom)};
        endcase
      end
      len7 = (ext_n == 0) ? wire_len[6:0] : (ext_n == 2) ? 7'd126 : 7'd127;
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back({masked, len7});
      for (i = ext_n; i > 0; i--)
        frame_bytes.push_back(wire_len[8*(i-1) +: 8]);
      if (masked)
        for (i = 0; i < 4; i++)
          frame_bytes.push_back(8'($urandom));
      // long frames only ever see a short buffer
      body = (wire_len > 200) ? $urandom_range(0, 12) : int'(wire_len);
      for (i = 0; i < body; i++)
        frame_bytes.push_back(8'($urandom));
      if (wire_len <= 200) begin
        if ($urandom_range(99) < 15 && frame_bytes.size() > 1) begin
          cut = $urandom_range(1, frame_bytes.size() - 1);
          while (frame_bytes.size() > cut)
            void'(frame_bytes.pop_back());
        end else if ($urandom_range(99) < 30) begin
          // trailing bytes after a complete frame
          body = $urandom_range(1, 3);
          for (i = 0; i < body; i++)
            frame_bytes.push_back(8'($urandom));
        end
      end
    end
  endtask

  // result sink stalls at random, except in the steady phase
  initial begin
    tx_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      tx_bus.ready <= steady || ($urandom_range(99) >= 28);
    end
  end

  // every tx transfer is checked against the oldest owed result
  always @(posedge clk) begin
    tx_item_t want;
    if (!rst && tx_bus.valid && tx_bus.ready) begin
      tx_count++;
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing owed");
      end else begin
        want = decoded_q.pop_front();
        check_field("payload_byte", tx_bus.payload_byte, want.payload_byte);
        check_field("byte_valid", tx_bus.byte_valid, want.byte_valid);
        check_field("frame_end", tx_bus.frame_end, want.frame_end);
        check_field("status", tx_bus.status, want.status);
        check_field("fin_bit", tx_bus.fin_bit, want.fin_bit);
        check_field("frame_opcode", tx_bus.frame_opcode, want.frame_opcode);
        check_field("payload_length", tx_bus.payload_length, want.payload_length);
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((rx_bus.valid && rx_bus.ready) || (tx_bus.valid && tx_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("FAIL websocket_frame_decoder_core");
    $finish;
  end

  initial begin
    int i, ph, sent;
    bit paused;
    rst = 1'b1;
    rx_bus.valid = 1'b0;
    rx_bus.data_byte = '0;
    rx_bus.buffer_end = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.out_capacity = '0;
    steady = 1'b0;
    mismatches = 0;
    tx_count = 0;
    capacity = MAX_PAYLOAD;
    clear_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed buffers at the reset capacity
    for (i = 0; i < DIR_ROWS; i++)
      push_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].kind, DIRECTED[i].lit);

    // random phases, each behind its own capacity setting
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      write_capacity(pick_capacity(ph));
      steady = (ph == 2);
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        build_random_buffer();
        for (i = 0; i < frame_bytes.size(); i++)
          push_byte(frame_bytes[i], i == frame_bytes.size() - 1, ROW_PREDICT, NO_RESULT);
        sent += frame_bytes.size();
        // mid-phase hold-off until the block has caught up
        if (ph % 3 == 1 && !paused && sent >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    steady = 1'b0;
    drain();

    if (mismatches == 0)
      $display("PASS websocket_frame_decoder_core");
    else
      $display("FAIL websocket_frame_decoder_core");
    $finish;
  end

endmodule
